[hdl/qte_pkg.sv]
// Shared constants, types and the arctangent table for the quaternion-to-Euler converter.
package qte_pkg;

    localparam int COMP_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    // Q.30 fixed-point formats used through the datapath.
    localparam int QW        = 34;  // sums of two doubled Q.30 products
    localparam int SW        = 32;  // clamped asin argument
    localparam int CW        = 36;  // CORDIC vector components, with growth margin
    localparam int RW        = 62;  // square-root remainder
    localparam int SQRT_BITS = 31;  // root bits, floor(sqrt(2^60)) = 2^30
    localparam int ANG_W     = 32;
    localparam int OUT_W     = 16;

    localparam logic signed [QW-1:0] ONE_Q30 = QW'(64'sd1 <<< 30);
    localparam logic [RW-1:0]        ONE_SQ  = RW'(64'd1 << 60);
    localparam logic [ANG_W-1:0]     ANG_PI  = 32'h8000_0000;
    localparam logic [ANG_W-1:0]     ANG_RND = 32'h0000_8000;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [ANG_W-1:0]     ang;
        logic                 zero;
        logic                 flag;
    } cord_t;

    // atan(2^-i) as a 32-bit binary angle, rounded to nearest.
    function automatic logic [ANG_W-1:0] atan_entry(input int unsigned idx);
        logic [ANG_W-1:0] r;
        case (idx)
            0:  r = 32'd536870912;
            1:  r = 32'd316933406;
            2:  r = 32'd167458907;
            3:  r = 32'd85004756;
            4:  r = 32'd42667331;
            5:  r = 32'd21354465;
            6:  r = 32'd10679838;
            7:  r = 32'd5340245;
            8:  r = 32'd2670163;
            9:  r = 32'd1335087;
            10: r = 32'd667544;
            11: r = 32'd333772;
            12: r = 32'd166886;
            13: r = 32'd83443;
            14: r = 32'd41722;
            15: r = 32'd20861;
            16: r = 32'd10430;
            17: r = 32'd5215;
            18: r = 32'd2608;
            19: r = 32'd1304;
            20: r = 32'd652;
            21: r = 32'd326;
            22: r = 32'd163;
            23: r = 32'd81;
            24: r = 32'd41;
            25: r = 32'd20;
            26: r = 32'd10;
            27: r = 32'd5;
            28: r = 32'd3;
            29: r = 32'd1;
            30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

[hdl/qte_sqrt_cell.sv]
// One digit of a pipelined restoring square root, carrying side data along.
module qte_sqrt_cell
    import qte_pkg::*;
#(
    parameter int BIT    = 0,
    parameter int SIDE_W = 1
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [RW-1:0]         rem_in,
    input  logic [SQRT_BITS-1:0]  root_in,
    input  logic [SIDE_W-1:0]     side_in,
    output logic [RW-1:0]         rem_reg,
    output logic [SQRT_BITS-1:0]  root_reg,
    output logic [SIDE_W-1:0]     side_reg
);

    logic [RW-1:0]        trial;
    logic [RW-1:0]        rem_next;
    logic [SQRT_BITS-1:0] root_next;

    // (r + 2^k)^2 - r^2 = r * 2^(k+1) + 2^(2k), where r holds only bits above k.
    always_comb begin
        trial = (RW'(root_in) << (BIT + 1)) + (RW'(1) << (2 * BIT));
        if (rem_in >= trial) begin
            rem_next  = rem_in - trial;
            root_next = root_in | (SQRT_BITS'(1) << BIT);
        end else begin
            rem_next  = rem_in;
            root_next = root_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end

endmodule

[hdl/qte_cordic_cell.sv]
// One vectoring CORDIC micro-rotation with its own pipeline register.
module qte_cordic_cell
    import qte_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic  aclk,
    input  logic  en,
    input  cord_t cin,
    output cord_t cout_reg
);

    cord_t                cout_next;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;

    always_comb begin
        xs        = cin.x >>> STEP;
        ys        = cin.y >>> STEP;
        cout_next = cin;
        if (cin.y > 0) begin
            cout_next.x   = cin.x + ys;
            cout_next.y   = cin.y - xs;
            cout_next.ang = cin.ang + atan_entry(STEP);
        end else begin
            cout_next.x   = cin.x - ys;
            cout_next.y   = cin.y + xs;
            cout_next.ang = cin.ang - atan_entry(STEP);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cout_reg <= cout_next;
        end
    end

endmodule

[hdl/quaternion_to_euler.sv]
// Top level: quaternion (w, x, y, z) in, roll, pitch and yaw binary angles out.
// Usage: present one quaternion per item on s_comp_w/x/y/z with s_valid; the
// item is taken when s_ready is high. Each item gives exactly one result on
// m_roll_angle, m_pitch_angle, m_yaw_angle and m_pitch_saturated with m_valid.
// The datapath is one pipeline of cells: a product stage, a sum and clamp
// stage, a square stage, the 2^60 - s^2 stage, 31 square-root digit cells,
// a pre-rotation stage, CORDIC_STEPS rotation cells per angle and an output
// register, 37 + CORDIC_STEPS stages (53 by default). One item is accepted
// per cycle while s_ready is high.
// Every stage has its own valid bit and advances when it is empty or the stage
// after it advances, so bubbles close up; when the receiver holds m_ready low,
// the block keeps taking items until every stage is full, then s_ready falls.
// The depth of the pipeline sets the latency.
// A synchronous low aresetn empties the pipeline; results in flight are dropped.
module quaternion_to_euler
    import qte_pkg::*;
#(
    parameter int COMP_BITS    = COMP_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [COMP_BITS-1:0] s_comp_w,
    input  logic signed [COMP_BITS-1:0] s_comp_x,
    input  logic signed [COMP_BITS-1:0] s_comp_y,
    input  logic signed [COMP_BITS-1:0] s_comp_z,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [OUT_W-1:0]     m_roll_angle,
    output logic signed [OUT_W-1:0]     m_pitch_angle,
    output logic signed [OUT_W-1:0]     m_yaw_angle,
    output logic                        m_pitch_saturated
);

    localparam int PW     = 2 * COMP_BITS;
    localparam int FRAC2  = 2 * (COMP_BITS - 1);
    localparam int SHR    = (FRAC2 > 30) ? FRAC2 - 30 : 0;
    localparam int SHL    = (FRAC2 < 30) ? 30 - FRAC2 : 0;
    localparam int SIDE_W = 4 * QW + SW + 1;

    localparam int ST_SUM  = 1;
    localparam int ST_SQ   = 2;
    localparam int ST_V    = 3;
    localparam int ST_ROOT = 4;
    localparam int ST_PRE  = ST_ROOT + SQRT_BITS;
    localparam int ST_CORD = ST_PRE + 1;
    localparam int ST_OUT  = ST_CORD + CORDIC_STEPS;
    localparam int NST     = ST_OUT + 1;

    localparam int P_ZY = 0;
    localparam int P_WX = 1;
    localparam int P_XX = 2;
    localparam int P_YY = 3;
    localparam int P_ZW = 4;
    localparam int P_XY = 5;
    localparam int P_WW = 6;
    localparam int P_YW = 7;
    localparam int P_ZX = 8;
    localparam int NPROD = 9;

    localparam int CH_ROLL  = 0;
    localparam int CH_PITCH = 1;
    localparam int CH_YAW   = 2;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] en;

    always_comb begin
        en[NST-1] = !vld_reg[NST-1] || m_ready;
        for (int i = NST - 2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int i = 1; i < NST; i++) begin
                if (en[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    assign s_ready = en[0];
    assign m_valid = vld_reg[NST-1];

    // Product stage.
    logic signed [PW-1:0] prod_reg [NPROD];

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            prod_reg[P_ZY] <= s_comp_z * s_comp_y;
            prod_reg[P_WX] <= s_comp_w * s_comp_x;
            prod_reg[P_XX] <= s_comp_x * s_comp_x;
            prod_reg[P_YY] <= s_comp_y * s_comp_y;
            prod_reg[P_ZW] <= s_comp_z * s_comp_w;
            prod_reg[P_XY] <= s_comp_x * s_comp_y;
            prod_reg[P_WW] <= s_comp_w * s_comp_w;
            prod_reg[P_YW] <= s_comp_y * s_comp_w;
            prod_reg[P_ZX] <= s_comp_z * s_comp_x;
        end
    end

    // Sum and clamp stage, everything in Q.30.
    logic signed [QW-1:0] q [NPROD];
    logic signed [QW-1:0] roll_y_next, roll_x_next, yaw_y_next, yaw_x_next, s_raw;
    logic signed [SW-1:0] s_next;
    logic                 sat_next;

    always_comb begin
        for (int i = 0; i < NPROD; i++) begin
            q[i] = QW'((64'(prod_reg[i]) <<< SHL) >>> SHR);
        end
        roll_y_next = (q[P_ZY] + q[P_WX]) <<< 1;
        roll_x_next = ONE_Q30 - ((q[P_XX] + q[P_YY]) <<< 1);
        yaw_y_next  = (q[P_ZW] + q[P_XY]) <<< 1;
        yaw_x_next  = ((q[P_WW] + q[P_XX]) <<< 1) - ONE_Q30;
        s_raw       = (q[P_YW] - q[P_ZX]) <<< 1;
        if (s_raw > ONE_Q30) begin
            s_next   = SW'(ONE_Q30);
            sat_next = 1'b1;
        end else if (s_raw < -ONE_Q30) begin
            s_next   = SW'(-ONE_Q30);
            sat_next = 1'b1;
        end else begin
            s_next   = SW'(s_raw);
            sat_next = 1'b0;
        end
    end

    logic [SIDE_W-1:0] side_sum_reg, side_sq_reg, side_v_reg;
    logic signed [SW-1:0] s_sum_reg;
    logic [RW-1:0] sq_reg, v_reg;
    logic signed [2*SW-1:0] s_prod;

    assign s_prod = s_sum_reg * s_sum_reg;

    always_ff @(posedge aclk) begin
        if (en[ST_SUM]) begin
            side_sum_reg <= {roll_y_next, roll_x_next, yaw_y_next, yaw_x_next, s_next, sat_next};
            s_sum_reg    <= s_next;
        end
        if (en[ST_SQ]) begin
            side_sq_reg <= side_sum_reg;
            sq_reg      <= RW'(s_prod);
        end
        if (en[ST_V]) begin
            side_v_reg <= side_sq_reg;
            v_reg      <= ONE_SQ - sq_reg;
        end
    end

    // Square-root cells, most significant root bit first.
    logic [RW-1:0]        rem   [SQRT_BITS+1];
    logic [SQRT_BITS-1:0] root  [SQRT_BITS+1];
    logic [SIDE_W-1:0]    side  [SQRT_BITS+1];

    assign rem[0]  = v_reg;
    assign root[0] = '0;
    assign side[0] = side_v_reg;

    for (genvar k = 0; k < SQRT_BITS; k++) begin : g_root
        qte_sqrt_cell #(
            .BIT    (SQRT_BITS - 1 - k),
            .SIDE_W (SIDE_W)
        ) u_cell (
            .aclk     (aclk),
            .en       (en[ST_ROOT + k]),
            .rem_in   (rem[k]),
            .root_in  (root[k]),
            .side_in  (side[k]),
            .rem_reg  (rem[k+1]),
            .root_reg (root[k+1]),
            .side_reg (side[k+1])
        );
    end

    // Pre-rotation: a vector with negative abscissa is turned by pi.
    logic signed [QW-1:0] r_roll_y, r_roll_x, r_yaw_y, r_yaw_x;
    logic signed [SW-1:0] r_s;
    logic                 r_sat;
    logic signed [CW-1:0] pre_y [3];
    logic signed [CW-1:0] pre_x [3];
    cord_t                pre_next [3];

    assign {r_roll_y, r_roll_x, r_yaw_y, r_yaw_x, r_s, r_sat} = side[SQRT_BITS];

    always_comb begin
        pre_y[CH_ROLL]  = CW'(r_roll_y);
        pre_x[CH_ROLL]  = CW'(r_roll_x);
        pre_y[CH_PITCH] = CW'(r_s);
        pre_x[CH_PITCH] = CW'({1'b0, root[SQRT_BITS]});
        pre_y[CH_YAW]   = CW'(r_yaw_y);
        pre_x[CH_YAW]   = CW'(r_yaw_x);
        for (int c = 0; c < 3; c++) begin
            pre_next[c].zero = (pre_x[c] == 0) && (pre_y[c] == 0);
            pre_next[c].flag = (c == CH_PITCH) ? r_sat : 1'b0;
            if (pre_x[c] < 0) begin
                pre_next[c].x   = -pre_x[c];
                pre_next[c].y   = -pre_y[c];
                pre_next[c].ang = ANG_PI;
            end else begin
                pre_next[c].x   = pre_x[c];
                pre_next[c].y   = pre_y[c];
                pre_next[c].ang = '0;
            end
        end
    end

    cord_t cd [3][CORDIC_STEPS+1];

    for (genvar c = 0; c < 3; c++) begin : g_pre
        always_ff @(posedge aclk) begin
            if (en[ST_PRE]) begin
                cd[c][0] <= pre_next[c];
            end
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_chan
        for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
            qte_cordic_cell #(
                .STEP (i)
            ) u_cell (
                .aclk     (aclk),
                .en       (en[ST_CORD + i]),
                .cin      (cd[c][i]),
                .cout_reg (cd[c][i+1])
            );
        end
    end

    // Round each 32-bit angle to 16 bits; a zero vector reads as angle zero.
    logic [ANG_W-1:0] ang_rnd [3];
    logic [OUT_W-1:0] ang_out [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            ang_rnd[c] = cd[c][CORDIC_STEPS].ang + ANG_RND;
            ang_out[c] = cd[c][CORDIC_STEPS].zero ? '0 : ang_rnd[c][ANG_W-1 -: OUT_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_OUT]) begin
            m_roll_angle      <= ang_out[CH_ROLL];
            m_pitch_angle     <= ang_out[CH_PITCH];
            m_yaw_angle       <= ang_out[CH_YAW];
            m_pitch_saturated <= cd[CH_PITCH][CORDIC_STEPS].flag;
        end
    end

endmodule

[bench/quaternion_to_euler_tb.sv]
// Self-checking testbench for the quaternion-to-Euler converter with bursty stimulus.
module quaternion_to_euler_tb;
    import qte_pkg::*;

    localparam int CORDIC_STEPS = CORDIC_STEPS_DEF;
    localparam int N_RANDOM     = 1500;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } quat_t;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic               sat;
    } euler_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_comp_w = '0;
    logic signed [15:0] s_comp_x = '0;
    logic signed [15:0] s_comp_y = '0;
    logic signed [15:0] s_comp_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [15:0] m_roll_angle;
    logic signed [15:0] m_pitch_angle;
    logic signed [15:0] m_yaw_angle;
    logic m_pitch_saturated;

    quat_t  pending_quats[$];
    euler_t expected_angles[$];
    int     errors = 0;
    int     n_checked = 0;
    int     n_sat = 0;
    int     n_directed = 0;

    quaternion_to_euler u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_comp_w(s_comp_w), .s_comp_x(s_comp_x),
        .s_comp_y(s_comp_y), .s_comp_z(s_comp_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_roll_angle(m_roll_angle), .m_pitch_angle(m_pitch_angle),
        .m_yaw_angle(m_yaw_angle), .m_pitch_saturated(m_pitch_saturated)
    );

    always #10 aclk = ~aclk;

    function automatic logic [15:0] round_angle(input logic [31:0] ang);
        logic [31:0] t;
        t = ang + ANG_RND;
        return t[31:16];
    endfunction

    // Vectoring CORDIC; the angle accumulates modulo 2^32.
    function automatic logic [31:0] cordic_angle(input longint vy, input longint vx);
        logic [31:0] ang;
        longint xs, ys, cx, cy;
        ang = '0;
        cx = vx;
        cy = vy;
        if (cx == 0 && cy == 0) return '0;
        if (cx < 0) begin
            cx = -cx;
            cy = -cy;
            ang = ANG_PI;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = cx >>> i;
            ys = cy >>> i;
            if (cy > 0) begin
                cx = cx + ys;
                cy = cy - xs;
                ang = ang + atan_entry(i);
            end else begin
                cx = cx - ys;
                cy = cy + xs;
                ang = ang - atan_entry(i);
            end
        end
        return ang;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned res, bitv, rem;
        res = 0;
        rem = v;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic euler_t predict_euler(input quat_t q);
        euler_t r;
        longint w, x, y, z, roll_y, roll_x, yaw_y, yaw_x, s, c;
        longint one;
        one = 64'sd1 <<< 30;
        w = q.w;
        x = q.x;
        y = q.y;
        z = q.z;
        roll_y = 2 * (z * y + w * x);
        roll_x = one - 2 * (x * x + y * y);
        yaw_y  = 2 * (z * w + x * y);
        yaw_x  = -one + 2 * (w * w + x * x);
        s      = 2 * (y * w - z * x);
        r.sat  = 1'b0;
        if (s > one) begin
            s = one;
            r.sat = 1'b1;
        end else if (s < -one) begin
            s = -one;
            r.sat = 1'b1;
        end
        c = longint'(floor_sqrt(longint'(one * one) - s * s));
        r.roll  = round_angle(cordic_angle(roll_y, roll_x));
        r.pitch = round_angle(cordic_angle(s, c));
        r.yaw   = round_angle(cordic_angle(yaw_y, yaw_x));
        return r;
    endfunction

    // Sender: bursts of items separated by idle gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        quat_t q;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_angles.push_back(predict_euler({s_comp_w, s_comp_x,
                                                         s_comp_y, s_comp_z}));
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (pending_quats.size() > 0) begin
                    q = pending_quats.pop_front();
                    s_comp_w <= q.w;
                    s_comp_x <= q.x;
                    s_comp_y <= q.y;
                    s_comp_z <= q.z;
                    s_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: runs of ready and stall with their own random lengths.
    int ready_run = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (ready_run > 0) begin
            ready_run <= ready_run - 1;
        end else begin
            m_ready <= ~m_ready;
            ready_run <= m_ready ? $urandom_range(0, 25) : $urandom_range(0, 60);
        end
    end

    always @(posedge aclk) begin
        euler_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (expected_angles.size() == 0) begin
                $display("%0t: result with no item outstanding: roll %0d pitch %0d yaw %0d",
                         $time, m_roll_angle, m_pitch_angle, m_yaw_angle);
                errors++;
            end else begin
                exp_r = expected_angles.pop_front();
                n_checked++;
                if (exp_r.sat) n_sat++;
                if (m_roll_angle !== exp_r.roll) begin
                    $display("%0t: roll expected %0d actual %0d", $time, exp_r.roll,
                             m_roll_angle);
                    errors++;
                end
                if (m_pitch_angle !== exp_r.pitch) begin
                    $display("%0t: pitch expected %0d actual %0d", $time, exp_r.pitch,
                             m_pitch_angle);
                    errors++;
                end
                if (m_yaw_angle !== exp_r.yaw) begin
                    $display("%0t: yaw expected %0d actual %0d", $time, exp_r.yaw,
                             m_yaw_angle);
                    errors++;
                end
                if (m_pitch_saturated !== exp_r.sat) begin
                    $display("%0t: saturation expected %0b actual %0b", $time, exp_r.sat,
                             m_pitch_saturated);
                    errors++;
                end
            end
        end
    end

    task automatic add_quat(input int w, input int x, input int y, input int z);
        quat_t q;
        q.w = 16'(w);
        q.x = 16'(x);
        q.y = 16'(y);
        q.z = 16'(z);
        pending_quats.push_back(q);
    endtask

    initial begin
        real rw, rx, ry, rz, norm, scale;
        add_quat(32767, 0, 0, 0);
        add_quat(0, 0, 0, 0);
        add_quat(-32768, -32768, -32768, -32768);
        add_quat(32767, 32767, 32767, 32767);
        add_quat(-32768, 32767, -32768, 32767);
        add_quat(32767, -32768, 32767, -32768);
        // Both atan2 operands zero, for yaw and for roll.
        add_quat(16384, 16384, 0, 0);
        add_quat(0, 16384, 16384, 0);
        // Negative abscissa with zero ordinate gives an angle of exactly pi.
        add_quat(0, 32767, 0, 0);
        add_quat(0, 0, 32767, 0);
        add_quat(0, 0, 0, 32767);
        // Asin argument beyond one in both directions, and right at the edge.
        add_quat(32767, 0, 32767, 0);
        add_quat(32767, 0, -32768, 0);
        add_quat(23170, 0, 23170, 0);
        add_quat(23170, 0, -23170, 0);
        add_quat(0, 23170, 0, 23170);
        add_quat(0, -23170, 0, 23170);
        add_quat(1, -1, 1, -1);
        add_quat(-1, 1, -1, 1);
        add_quat(23170, 23170, 0, 0);
        add_quat(-16384, 16384, -16384, 16384);
        n_directed = pending_quats.size();
        for (int i = 0; i < N_RANDOM; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                add_quat($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                         $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768);
            end else begin
                // Near-unit quaternion, as a sensor fusion filter delivers.
                rw = $urandom_range(0, 65535) - 32768.0;
                rx = $urandom_range(0, 65535) - 32768.0;
                ry = $urandom_range(0, 65535) - 32768.0;
                rz = $urandom_range(0, 65535) - 32768.0;
                norm = $sqrt(rw * rw + rx * rx + ry * ry + rz * rz);
                if (norm < 1.0) norm = 1.0;
                scale = (32000.0 + $urandom_range(0, 760)) / norm;
                add_quat($rtoi(rw * scale), $rtoi(rx * scale), $rtoi(ry * scale),
                         $rtoi(rz * scale));
            end
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_quats.size() == 0);
        @(posedge aclk);
        while (s_valid || expected_angles.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("Checked %0d results from %0d directed and %0d random quaternions.",
                 n_checked, n_directed, N_RANDOM);
        $display("%0d results had a clamped asin argument.", n_sat);
        if (errors == 0 && m_valid == 1'b0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #(20 * 400000);
        $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
hdl/qte_pkg.sv
hdl/qte_sqrt_cell.sv
hdl/qte_cordic_cell.sv
hdl/quaternion_to_euler.sv
bench/quaternion_to_euler_tb.sv
